>>> src/tpc_pkg.sv
// Shared types, widths, status codes and helpers of the three-point curvature block.
package tpc_pkg;

    localparam int DW = 32;
    localparam int FB = 16;

    // Squared lengths and the numerator magnitude need one bit over two data words.
    localparam int LW = 2 * DW + 1;
    localparam int PW = 2 * DW;
    localparam int NW = 2 * DW + 2;
    localparam int TW = 4 * DW + 2;
    localparam int WA = 8 * DW + 4;
    localparam int WB = 4 * DW + 4 + 4 * FB;
    localparam int W  = (WA > WB) ? WA : WB;
    localparam int KW = $clog2(DW);
    localparam int NUM_SHIFT = 2 + 4 * FB;
    localparam int D_SHIFT = 2 * (DW - 1);

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        logic signed [DW-1:0] x_coord;
        logic signed [DW-1:0] y_coord;
        logic                 curve_start;
    } t_in_item;

    typedef struct packed {
        logic signed [DW-1:0] curvature;
        logic [1:0]           status;
    } t_out_item;

    // Magnitude of a difference of two points; it always fits in DW bits.
    function automatic logic [DW-1:0] mag_d(input logic signed [DW:0] v);
        logic [DW:0] t;
        t = v[DW] ? (~v + 1'b1) : v;
        return t[DW-1:0];
    endfunction

endpackage

>>> src/three_point_curvature.sv
// Top level of the three-point curvature block: window, sequencer and shared datapath.
//
// Each accepted point shifts a three-point window; from the third point of a curve on,
// one transfer of signed curvature and status follows. The window differences are
// registered when the point is accepted. A full window then runs eleven products on one
// shift-add multiply-accumulate unit, one multiplier bit per cycle, then a bit-at-a-time
// magnitude search from the top result bit down, then saturation and the hand-over.
// A zero x spacing or a degenerate window is reported from the check state, before any
// product is run. The input stalls for the whole computation; the result register frees
// the input side while a result waits to be taken.
module three_point_curvature (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tpc_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tpc_pkg::t_out_item  o_out_data
);
    import tpc_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_LOAD  = 4'd2;
    localparam logic [3:0] S_RUN   = 4'd3;
    localparam logic [3:0] S_NCOMB = 4'd4;
    localparam logic [3:0] S_SA    = 4'd5;
    localparam logic [3:0] S_SB    = 4'd6;
    localparam logic [3:0] S_RES   = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    localparam logic [3:0] J_AA  = 4'd0;
    localparam logic [3:0] J_DD1 = 4'd1;
    localparam logic [3:0] J_BB  = 4'd2;
    localparam logic [3:0] J_DD2 = 4'd3;
    localparam logic [3:0] J_EE  = 4'd4;
    localparam logic [3:0] J_FF  = 4'd5;
    localparam logic [3:0] J_P   = 4'd6;
    localparam logic [3:0] J_Q   = 4'd7;
    localparam logic [3:0] J_NN  = 4'd8;
    localparam logic [3:0] J_L12 = 4'd9;
    localparam logic [3:0] J_DEN = 4'd10;

    localparam logic [DW-1:0] HALF = {1'b1, {(DW-1){1'b0}}};

    logic [3:0]           r_state;
    logic signed [DW-1:0] r_mid_x, r_mid_y, r_old_x, r_old_y;
    logic [1:0]           r_seen;
    logic                 r_go;
    logic signed [DW:0]   r_a, r_b, r_d1, r_d2, r_e, r_f;
    logic [3:0]           r_job;
    logic [W-1:0]         r_acc, r_mc;
    logic [LW-1:0]        r_ml;
    logic [LW-1:0]        r_l1, r_l2, r_l3, r_nmag;
    logic [PW-1:0]        r_p, r_q;
    logic [TW-1:0]        r_t;
    logic                 r_neg;
    logic [W-1:0]         r_num, r_s, r_pp, r_d, r_u, r_pc;
    logic [DW-1:0]        r_qv;
    logic [KW-1:0]        r_k;
    logic [DW-1:0]        r_res_cv;
    logic [1:0]           r_res_st;
    logic                 r_ov;
    t_out_item            r_od;

    logic                 in_acc;
    logic [1:0]           seen_eff;
    logic signed [DW-1:0] mid_x_eff, mid_y_eff, old_x_eff, old_y_eff;
    logic [W-1:0]         mac_sum, u_sum, pc_sum, v_sum;
    logic signed [NW-1:0] p_ext, q_ext, sp_v, sq_v, n_val, n_abs;
    logic                 sat;
    logic [DW-1:0]        cv_final;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;

    always_comb begin
        if (i_in_data.curve_start) begin
            seen_eff  = 2'd0;
            mid_x_eff = '0;
            mid_y_eff = '0;
            old_x_eff = '0;
            old_y_eff = '0;
        end else begin
            seen_eff  = r_seen;
            mid_x_eff = r_mid_x;
            mid_y_eff = r_mid_y;
            old_x_eff = r_old_x;
            old_y_eff = r_old_y;
        end
    end

    assign mac_sum = r_acc + r_mc;
    assign u_sum   = r_s + r_pp;
    assign pc_sum  = (r_pp >> 1) + r_d;
    assign v_sum   = r_u + r_d;

    // Numerator N = d1*b - d2*a from the two product magnitudes and their signs.
    always_comb begin
        p_ext = signed'({2'b00, r_p});
        q_ext = signed'({2'b00, r_q});
        sp_v  = (r_d1[DW] ^ r_b[DW]) ? -p_ext : p_ext;
        sq_v  = (r_d2[DW] ^ r_a[DW]) ? -q_ext : q_ext;
        n_val = sp_v - sq_v;
        n_abs = n_val[NW-1] ? -n_val : n_val;
    end

    always_comb begin
        sat = r_neg ? (r_qv > HALF) : (r_qv >= HALF);
        if (sat) begin
            cv_final = r_neg ? HALF : ~HALF;
        end else begin
            cv_final = r_neg ? (~r_qv + 1'b1) : r_qv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mid_x <= '0;
            r_mid_y <= '0;
            r_old_x <= '0;
            r_old_y <= '0;
            r_seen  <= 2'd0;
            r_ov    <= 1'b0;
        end else begin
            // In the hand-over state the valid flag is driven by that state alone.
            if (r_ov && !i_out_stall && r_state != S_FIN) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_a  <= {mid_x_eff[DW-1], mid_x_eff} - {old_x_eff[DW-1], old_x_eff};
                        r_d1 <= {mid_y_eff[DW-1], mid_y_eff} - {old_y_eff[DW-1], old_y_eff};
                        r_b  <= {i_in_data.x_coord[DW-1], i_in_data.x_coord}
                                - {mid_x_eff[DW-1], mid_x_eff};
                        r_d2 <= {i_in_data.y_coord[DW-1], i_in_data.y_coord}
                                - {mid_y_eff[DW-1], mid_y_eff};
                        r_e  <= {i_in_data.x_coord[DW-1], i_in_data.x_coord}
                                - {old_x_eff[DW-1], old_x_eff};
                        r_f  <= {i_in_data.y_coord[DW-1], i_in_data.y_coord}
                                - {old_y_eff[DW-1], old_y_eff};
                        r_go    <= (seen_eff >= 2'd2);
                        r_old_x <= mid_x_eff;
                        r_old_y <= mid_y_eff;
                        r_mid_x <= i_in_data.x_coord;
                        r_mid_y <= i_in_data.y_coord;
                        r_seen  <= (seen_eff >= 2'd2) ? 2'd2 : seen_eff + 2'd1;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (!r_go) begin
                        r_state <= S_IDLE;
                    end else if (r_a == '0 || r_b == '0 || (r_e == '0 && r_f == '0)) begin
                        r_res_cv <= '0;
                        r_res_st <= ST_ZERO;
                        r_state  <= S_FIN;
                    end else begin
                        r_job   <= J_AA;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    // Sums of squares keep accumulating onto the first square.
                    if (r_job != J_DD1 && r_job != J_DD2 && r_job != J_FF) begin
                        r_acc <= '0;
                    end
                    case (r_job)
                        J_AA: begin
                            r_mc <= W'(mag_d(r_a));
                            r_ml <= LW'(mag_d(r_a));
                        end
                        J_DD1: begin
                            r_mc <= W'(mag_d(r_d1));
                            r_ml <= LW'(mag_d(r_d1));
                        end
                        J_BB: begin
                            r_mc <= W'(mag_d(r_b));
                            r_ml <= LW'(mag_d(r_b));
                        end
                        J_DD2: begin
                            r_mc <= W'(mag_d(r_d2));
                            r_ml <= LW'(mag_d(r_d2));
                        end
                        J_EE: begin
                            r_mc <= W'(mag_d(r_e));
                            r_ml <= LW'(mag_d(r_e));
                        end
                        J_FF: begin
                            r_mc <= W'(mag_d(r_f));
                            r_ml <= LW'(mag_d(r_f));
                        end
                        J_P: begin
                            r_mc <= W'(mag_d(r_d1));
                            r_ml <= LW'(mag_d(r_b));
                        end
                        J_Q: begin
                            r_mc <= W'(mag_d(r_d2));
                            r_ml <= LW'(mag_d(r_a));
                        end
                        J_NN: begin
                            r_mc <= W'(r_nmag);
                            r_ml <= r_nmag;
                        end
                        J_L12: begin
                            r_mc <= W'(r_l1);
                            r_ml <= r_l2;
                        end
                        default: begin
                            r_mc <= W'(r_t);
                            r_ml <= r_l3;
                        end
                    endcase
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (r_ml != '0) begin
                        if (r_ml[0]) begin
                            r_acc <= mac_sum;
                        end
                        r_mc <= r_mc << 1;
                        r_ml <= r_ml >> 1;
                    end else begin
                        r_job   <= r_job + 4'd1;
                        r_state <= S_LOAD;
                        case (r_job)
                            J_DD1: r_l1 <= r_acc[LW-1:0];
                            J_DD2: r_l2 <= r_acc[LW-1:0];
                            J_FF:  r_l3 <= r_acc[LW-1:0];
                            J_P:   r_p  <= r_acc[PW-1:0];
                            J_Q: begin
                                r_q     <= r_acc[PW-1:0];
                                r_state <= S_NCOMB;
                            end
                            J_NN:  r_num <= r_acc << NUM_SHIFT;
                            J_L12: r_t   <= r_acc[TW-1:0];
                            J_DEN: begin
                                r_s     <= '0;
                                r_pp    <= '0;
                                r_d     <= r_acc << D_SHIFT;
                                r_qv    <= '0;
                                r_k     <= KW'(DW - 1);
                                r_state <= S_SA;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_NCOMB: begin
                    if (n_val == '0) begin
                        r_res_cv <= '0;
                        r_res_st <= ST_OK;
                        r_state  <= S_FIN;
                    end else begin
                        r_nmag  <= n_abs[LW-1:0];
                        r_neg   <= (~n_val[NW-1]) ^ (r_a[DW] ^ r_b[DW]);
                        r_job   <= J_NN;
                        r_state <= S_LOAD;
                    end
                end
                S_SA: begin
                    r_u     <= u_sum;
                    r_pc    <= pc_sum;
                    r_state <= S_SB;
                end
                S_SB: begin
                    // Try setting bit k: (q + 2^k)^2 * den against the scaled numerator.
                    if (v_sum <= r_num) begin
                        r_s       <= v_sum;
                        r_pp      <= r_pc;
                        r_qv[r_k] <= 1'b1;
                    end else begin
                        r_pp <= r_pp >> 1;
                    end
                    r_d <= r_d >> 2;
                    if (r_k == '0) begin
                        r_state <= S_RES;
                    end else begin
                        r_k     <= r_k - 1'b1;
                        r_state <= S_SA;
                    end
                end
                S_RES: begin
                    r_res_cv <= cv_final;
                    r_res_st <= sat ? ST_SAT : ST_OK;
                    r_state  <= S_FIN;
                end
                S_FIN: begin
                    if (!r_ov || !i_out_stall) begin
                        r_ov           <= 1'b1;
                        r_od.curvature <= r_res_cv;
                        r_od.status    <= r_res_st;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> src/tpc_checker.sv
// Port-level checker for the three-point curvature block, bound to its top level.
module tpc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input tpc_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input tpc_pkg::t_out_item o_out_data
);
    import tpc_pkg::*;

    localparam logic [DW-1:0] CV_MIN = {1'b1, {(DW-1){1'b0}}};

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while its transfer was stalled");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status <= ST_SAT)
        else $error("undefined status code");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_ZERO |-> o_out_data.curvature == '0)
        else $error("zero spacing status with nonzero curvature");

    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_SAT |->
            o_out_data.curvature == CV_MIN || o_out_data.curvature == ~CV_MIN)
        else $error("saturated status without a limit value");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not held off after a transfer");

    wire unused_ok = i_in_data.curve_start;

endmodule

bind three_point_curvature tpc_checker u_tpc_checker (.*);

>>> verif/three_point_curvature_checker.sv
// Checker for the three-point curvature block: watches both channels and predicts results.
`timescale 1ns / 1ps

module three_point_curvature_checker
    import tpc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  t_in_item   i_in_data,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  t_out_item  i_out_data,
    output int         o_errors,
    output int         o_pending
);

    // Point window of the current curve.
    longint    prev_x, prev_y, early_x, early_y;
    int        held_points;
    t_out_item expected_curvatures[$];

    function automatic logic [319:0] square_of(input longint v);
        logic [319:0] m;
        m = (v < 0) ? -v : v;
        return m * m;
    endfunction

    function automatic t_out_item curvature_at(input longint x0, input longint y0,
                                               input longint x1, input longint y1,
                                               input longint x2, input longint y2);
        t_out_item           r;
        longint              a, b, d1, d2;
        logic [319:0]        l1, l2, l3, den, num, t;
        logic signed [129:0] sa, sb, sd1, sd2, n;
        logic [129:0]        nm;
        logic [63:0]         lo, hi, mid, lim;
        bit                  neg;
        a = x1 - x0;
        b = x2 - x1;
        d1 = y1 - y0;
        d2 = y2 - y1;
        r.curvature = '0;
        r.status = ST_ZERO;
        if (a == 0 || b == 0) return r;
        l1 = square_of(a) + square_of(d1);
        l2 = square_of(b) + square_of(d2);
        l3 = square_of(x2 - x0) + square_of(y2 - y0);
        if (l3 == 0) return r;
        r.status = ST_OK;
        sa = a;
        sb = b;
        sd1 = d1;
        sd2 = d2;
        n = sd1 * sb - sd2 * sa;
        if (n == 0) return r;
        neg = (n > 0) != ((a < 0) != (b < 0));
        nm = (n < 0) ? -n : n;
        num = nm;
        num = num * num;
        num = num << NUM_SHIFT;
        den = l1 * l2;
        den = den * l3;
        lo = 0;
        hi = (64'd1 << (DW - 1)) + 1;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            t = mid;
            t = t * t;
            t = t * den;
            if (t <= num) lo = mid;
            else hi = mid - 1;
        end
        lim = (64'd1 << (DW - 1)) - (neg ? 0 : 1);
        if (lo > lim) begin
            lo = lim;
            r.status = ST_SAT;
        end
        r.curvature = neg ? -lo[DW-1:0] : lo[DW-1:0];
        return r;
    endfunction

    assign o_pending = expected_curvatures.size();

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            prev_x <= 0;
            prev_y <= 0;
            early_x <= 0;
            early_y <= 0;
            held_points <= 0;
            o_errors <= 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                longint px, py, ex, ey;
                int     cnt;
                px = prev_x;
                py = prev_y;
                ex = early_x;
                ey = early_y;
                cnt = held_points;
                if (i_in_data.curve_start) begin
                    px = 0; py = 0; ex = 0; ey = 0; cnt = 0;
                end
                if (cnt >= 2)
                    expected_curvatures.insert(expected_curvatures.size(),
                        curvature_at(ex, ey, px, py,
                        longint'(i_in_data.x_coord), longint'(i_in_data.y_coord)));
                early_x <= px;
                early_y <= py;
                prev_x <= longint'(i_in_data.x_coord);
                prev_y <= longint'(i_in_data.y_coord);
                held_points <= (cnt < 2) ? cnt + 1 : 2;
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_curvatures.size() == 0) begin
                    $display("%0t: unexpected result transfer curvature %0d status %0d",
                             $time, i_out_data.curvature, i_out_data.status);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_curvatures.pop_front();
                    if (want.curvature !== i_out_data.curvature ||
                        want.status !== i_out_data.status) begin
                        $display("%0t: mismatch expected curvature %0d status %0d, got %0d %0d",
                                 $time, want.curvature, want.status,
                                 i_out_data.curvature, i_out_data.status);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

>>> verif/three_point_curvature_tb.sv
// Testbench top for the three-point curvature block: clock, stimulus and verdict.
`timescale 1ns / 1ps

module three_point_curvature_tb;
    import tpc_pkg::*;

    localparam int N_RANDOM = 730;
    localparam int QUIET_TAIL = 100;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_data;
    int        errors;
    int        pending;
    int        points_sent;
    bit        quiet;

    three_point_curvature dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data)
    );

    three_point_curvature_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    // Result side: random stall bursts, one long hold-off to back the block up.
    initial begin
        bit held;
        held = 0;
        out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && points_sent >= 40) begin
                held = 1;
                out_stall = 1'b1;
                repeat (4000) @(negedge i_clk);
                out_stall = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
                out_stall = 1'b0;
            end
        end
    end

    task automatic send_point(input longint x, input longint y, input bit start);
        bit stalled;
        @(negedge i_clk);
        in_valid = 1'b1;
        in_data.x_coord = x[DW-1:0];
        in_data.y_coord = y[DW-1:0];
        in_data.curve_start = start;
        forever begin
            #1 stalled = in_stall;
            @(posedge i_clk);
            if (!stalled) break;
            @(negedge i_clk);
        end
        points_sent++;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            @(negedge i_clk);
            in_valid = 1'b0;
            repeat ($urandom_range(1, 12) - 1) @(negedge i_clk);
        end
    endtask

    function automatic longint rand_coord();
        return longint'($signed($urandom()));
    endfunction

    initial begin
        longint x, y, fx, fy, sx, sy;
        int     len, kind;
        in_valid = 1'b0;
        in_data = '0;
        points_sent = 0;
        quiet = 0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Short curves are cut by a start flag before a result appears.
        send_point(0, 0, 1);
        send_point(65536, 65536, 0);
        send_point(10, 10, 1);
        // Straight line: zero numerator.
        send_point(0, 0, 0);
        send_point(65536, 65536, 0);
        send_point(131072, 131072, 0);
        // Unit circle arc.
        send_point(-65536, 0, 1);
        send_point(0, 65536, 0);
        send_point(65536, 0, 0);
        // Zero x spacing on either side.
        send_point(65536, 3, 0);
        send_point(65536, 7, 0);
        // Third point back on the first one.
        send_point(0, 0, 1);
        send_point(5, 9, 0);
        send_point(0, 0, 0);
        // Tiny spacing with a huge jump saturates, both signs.
        send_point(0, 0, 1);
        send_point(1, 32'h7fffffff, 0);
        send_point(2, 0, 0);
        send_point(3, 32'h7fffffff, 0);
        // Coordinate extremes.
        send_point(-2147483648, -2147483648, 1);
        send_point(2147483647, 2147483647, 0);
        send_point(-2147483648, 2147483647, 0);
        send_point(2147483647, -2147483648, 0);
        send_point(-1, -1, 0);

        for (int i = 0; i < N_RANDOM; ) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                // Noise: arbitrary points with arbitrary start flags.
                send_point(rand_coord(), rand_coord(), $urandom_range(0, 1));
                i++;
            end else begin
                len = $urandom_range(3, 10);
                x = (kind < 4) ? rand_coord() : longint'($urandom_range(0, 65535)) - 32768;
                y = (kind < 4) ? rand_coord() : longint'($urandom_range(0, 65535)) - 32768;
                fx = x;
                fy = y;
                for (int k = 0; k < len && i < N_RANDOM; k++) begin
                    if (i >= N_RANDOM - QUIET_TAIL) quiet = 1;
                    send_point(x, y, k == 0);
                    i++;
                    if (k == 0) begin
                        sx = x;
                        sy = y;
                    end
                    case ($urandom_range(0, 9))
                        0: x = x;
                        1: begin x = fx; y = fy; end
                        2: begin x = rand_coord(); y = rand_coord(); end
                        3: begin x = x + 1; y = y + rand_coord(); end
                        default: begin
                            x = x + $urandom_range(1, 200000) * (($urandom_range(0, 3) == 0) ? -1 : 1);
                            y = y + longint'($urandom_range(0, 400000)) - 200000;
                        end
                    endcase
                    x = longint'($signed(x[DW-1:0]));
                    y = longint'($signed(y[DW-1:0]));
                    fx = sx;
                    fy = sy;
                    sx = x;
                    sy = y;
                end
            end
        end
        @(negedge i_clk);
        in_valid = 1'b0;
        quiet = 1;
        while (pending != 0) @(posedge i_clk);
        repeat (1000) @(posedge i_clk);
        if (errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule
